### hw/rtl/eip_pkg.sv
// Shared constants and types for the Ethernet/IP/L4 header parser.
// No dependencies.
package eip_pkg;
  localparam int FRAME_COUNT_BITS = 16;
  localparam int CAP_BYTES = 68;
  localparam int RUN_LEN = 15;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [3:0] TAG_CLASS = 4'd0;
  localparam logic [3:0] TAG_ECN = 4'd1;
  localparam logic [3:0] TAG_DST_MAC = 4'd2;
  localparam logic [3:0] TAG_SRC_MAC = 4'd3;
  localparam logic [3:0] TAG_REM_HI = 4'd4;
  localparam logic [3:0] TAG_REM_LO = 4'd5;
  localparam logic [3:0] TAG_LOC_HI = 4'd6;
  localparam logic [3:0] TAG_LOC_LO = 4'd7;
  localparam logic [3:0] TAG_FAMILY = 4'd8;
  localparam logic [3:0] TAG_REM_PORT = 4'd9;
  localparam logic [3:0] TAG_LOC_PORT = 4'd10;
  localparam logic [3:0] TAG_POFF = 4'd11;
  localparam logic [3:0] TAG_PLEN = 4'd12;
  localparam logic [3:0] TAG_SEQ = 4'd13;
  localparam logic [3:0] TAG_ACK = 4'd14;
  localparam logic [3:0] TAG_LAST = 4'd14;

  localparam logic [2:0] CLS_DROP = 3'd0;
  localparam logic [2:0] CLS_UDP = 3'd1;
  localparam logic [2:0] CLS_TCP_DATA = 3'd2;
  localparam logic [2:0] CLS_SYN = 3'd3;
  localparam logic [2:0] CLS_SYNACK = 3'd4;
  localparam logic [2:0] CLS_FIN = 3'd5;

  // One classified frame, handed from the parser to the emitter.
  typedef struct packed {
    logic [2:0]  cls;
    logic [1:0]  ecn;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [63:0] rem_hi;
    logic [63:0] rem_lo;
    logic [63:0] loc_hi;
    logic [63:0] loc_lo;
    logic        is_v6;
    logic [15:0] rem_port;
    logic [15:0] loc_port;
    logic [6:0]  poff;
    logic [15:0] plen;
    logic [31:0] seq;
    logic [31:0] ack;
  } frame_rec_t;
endpackage

### hw/rtl/eip_if.sv
// Valid/ready channel interfaces for the parser.
// Depends on nothing.
interface eip_byte_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;
  modport source (output valid, data_byte, end_of_frame, input ready);
  modport sink (input valid, data_byte, end_of_frame, output ready);
endinterface

interface eip_field_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [3:0]  field_tag;
  logic [63:0] field_value;
  logic        last_of_run;
  modport source (output valid, field_tag, field_value, last_of_run, input ready);
  modport sink (input valid, field_tag, field_value, last_of_run, output ready);
endinterface

### hw/rtl/eth_ip_l4_header_parser.sv
// Top level of the Ethernet/IPv4/IPv6/UDP/TCP header parser.
// Depends on eip_pkg, eip_if, eip_parse, eip_queue, eip_emit.
//
//  channel  | dir | payload
//  in_ch    | in  | data_byte, end_of_frame
//  out_ch   | out | field_tag, field_value, last_of_run
//
// Bytes are taken one per cycle; the last byte is classified in that cycle.
// A frame yields 1 (drop) or 15 output beats, one per cycle from the emitter while out_ready is high.
// Up to four classified frames wait in the queue and one more at the parser
// output; bytes stall only while both are full.
// Reset (rst, synchronous) clears counters and queue pointers.
module eth_ip_l4_header_parser (
  input logic clk,
  input logic rst,
  eip_byte_if.sink    in_ch,
  eip_field_if.source out_ch
);
  import eip_pkg::*;

  logic pv, pr, qv, qr;
  frame_rec_t prec, qrec;

  eip_parse u_parse (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .data_byte(in_ch.data_byte), .end_of_frame(in_ch.end_of_frame),
    .rec_valid(pv), .rec_ready(pr), .rec(prec)
  );

  eip_queue u_queue (
    .clk, .rst,
    .wr_valid(pv), .wr_ready(pr), .wr_data(prec),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qrec)
  );

  eip_emit u_emit (
    .clk, .rst,
    .rec_valid(qv), .rec_ready(qr), .rec(qrec),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .field_tag(out_ch.field_tag), .field_value(out_ch.field_value),
    .last_of_run(out_ch.last_of_run)
  );
endmodule

### hw/rtl/eip_parse.sv
// Front part: captures frame bytes, classifies the frame at its last byte.
// Depends on eip_pkg.
module eip_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                end_of_frame,
  output logic                rec_valid,
  input  logic                rec_ready,
  output eip_pkg::frame_rec_t rec
);
  import eip_pkg::*;

  localparam logic [FRAME_COUNT_BITS-1:0] MAX_COUNT = '1;

  logic [7:0] cap [CAP_BYTES];
  logic [FRAME_COUNT_BITS-1:0] byte_position;
  logic [FRAME_COUNT_BITS-1:0] len;
  logic fire, hold_valid;
  frame_rec_t r, hold;

  // One record held at the output; new frame ends may overwrite only if taken.
  assign in_ready = !hold_valid || rec_ready;
  assign fire = in_valid && in_ready;
  assign rec_valid = hold_valid;
  assign rec = hold;

  always_ff @(posedge clk) begin
    if (fire && byte_position < FRAME_COUNT_BITS'(CAP_BYTES))
      cap[byte_position[6:0]] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      hold_valid <= 1'b0;
    end else begin
      if (rec_ready) hold_valid <= 1'b0;
      if (fire) begin
        if (end_of_frame) begin
          byte_position <= '0;
          hold_valid <= 1'b1;
        end else if (byte_position != MAX_COUNT) begin
          byte_position <= byte_position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && end_of_frame) hold <= r;
  end

  // Capture view that includes the current (possibly last) byte.
  function automatic logic [7:0] cb(input logic [6:0] k, input logic [7:0] cur,
                                    input logic [FRAME_COUNT_BITS-1:0] pos);
    logic [7:0] v;
    v = cap[k];
    if (FRAME_COUNT_BITS'(k) == pos) v = cur;
    return v;
  endfunction

  logic [FRAME_COUNT_BITS-1:0] iplen, tot, pl, tl, ul, hl;
  logic [6:0] t;
  logic [7:0] proto, flags, b0, b14, b15, thl;
  logic ok, v4, v6, udp, tcp;
  logic [2:0] cls;

  always_comb begin
    len = (byte_position == MAX_COUNT) ? byte_position : byte_position + 1'b1;
    iplen = len - FRAME_COUNT_BITS'(14);
    b0 = cb(7'd0, data_byte, byte_position);
    b14 = cb(7'd14, data_byte, byte_position);
    b15 = cb(7'd15, data_byte, byte_position);
    v4 = {cb(7'd12, data_byte, byte_position), cb(7'd13, data_byte, byte_position)}
         == 16'h0800;
    v6 = {cb(7'd12, data_byte, byte_position), cb(7'd13, data_byte, byte_position)}
         == 16'h86DD;
    tot = FRAME_COUNT_BITS'({cb(7'd16, data_byte, byte_position),
                             cb(7'd17, data_byte, byte_position)});
    pl = FRAME_COUNT_BITS'({cb(7'd18, data_byte, byte_position),
                            cb(7'd19, data_byte, byte_position)});
    ok = (len >= FRAME_COUNT_BITS'(14)) && !b0[0];
    t = v6 ? 7'd54 : 7'd34;
    tl = v6 ? pl : tot - FRAME_COUNT_BITS'(20);
    if (v4) begin
      ok = ok && iplen >= FRAME_COUNT_BITS'(20) && b14 == 8'h45 && iplen >= tot &&
           tot >= FRAME_COUNT_BITS'(20)
           && {8'd0, cb(7'd16, data_byte, byte_position),
               cb(7'd17, data_byte, byte_position)} <= 24'(MAX_COUNT);
      proto = cb(7'd23, data_byte, byte_position);
    end else if (v6) begin
      ok = ok && iplen >= FRAME_COUNT_BITS'(40) &&
           {1'b0, pl} + 17'd40 <= {1'b0, iplen} &&
           {cb(7'd18, data_byte, byte_position),
            cb(7'd19, data_byte, byte_position)} <= 16'(MAX_COUNT);
      proto = cb(7'd20, data_byte, byte_position);
    end else begin
      ok = 1'b0;
      proto = 8'd0;
    end
    udp = proto == 8'd17;
    tcp = proto == 8'd6;
    ul = FRAME_COUNT_BITS'({cb(t + 7'd4, data_byte, byte_position),
                            cb(t + 7'd5, data_byte, byte_position)});
    thl = cb(t + 7'd12, data_byte, byte_position);
    hl = FRAME_COUNT_BITS'({thl[7:4], 2'b00});
    flags = cb(t + 7'd13, data_byte, byte_position);
    cls = CLS_DROP;
    if (udp) begin
      if (tl >= FRAME_COUNT_BITS'(8) && tl >= ul && ul >= FRAME_COUNT_BITS'(8) &&
          {cb(t + 7'd4, data_byte, byte_position),
           cb(t + 7'd5, data_byte, byte_position)} <= 16'(MAX_COUNT))
        cls = CLS_UDP;
    end else if (tcp) begin
      if (tl >= FRAME_COUNT_BITS'(20) && hl >= FRAME_COUNT_BITS'(20) && tl >= hl) begin
        if (flags == 8'h10 && tl != hl) cls = CLS_TCP_DATA;
        else if (flags[1]) cls = flags[4] ? CLS_SYNACK : CLS_SYN;
        else if (flags[0]) cls = CLS_FIN;
      end
    end
    if (!ok) cls = CLS_DROP;

    r.cls = cls;
    r.is_v6 = v6;
    r.ecn = v6 ? b15[5:4] : b15[1:0];
    for (int i = 0; i < 6; i++) begin
      r.dst_mac[47-8*i -: 8] = cb(7'(i), data_byte, byte_position);
      r.src_mac[47-8*i -: 8] = cb(7'(6 + i), data_byte, byte_position);
    end
    for (int i = 0; i < 8; i++) begin
      r.rem_hi[63-8*i -: 8] = cb(7'(22 + i), data_byte, byte_position);
      r.rem_lo[63-8*i -: 8] = cb(7'(30 + i), data_byte, byte_position);
      r.loc_hi[63-8*i -: 8] = cb(7'(38 + i), data_byte, byte_position);
      r.loc_lo[63-8*i -: 8] = cb(7'(46 + i), data_byte, byte_position);
    end
    if (!v6) begin
      r.rem_hi = '0;
      r.loc_hi = '0;
      r.rem_lo = {32'd0, cb(7'd26, data_byte, byte_position),
                  cb(7'd27, data_byte, byte_position),
                  cb(7'd28, data_byte, byte_position),
                  cb(7'd29, data_byte, byte_position)};
      r.loc_lo = {32'd0, cb(7'd30, data_byte, byte_position),
                  cb(7'd31, data_byte, byte_position),
                  cb(7'd32, data_byte, byte_position),
                  cb(7'd33, data_byte, byte_position)};
    end
    r.rem_port = {cb(t, data_byte, byte_position), cb(t + 7'd1, data_byte, byte_position)};
    r.loc_port = {cb(t + 7'd2, data_byte, byte_position),
                  cb(t + 7'd3, data_byte, byte_position)};
    r.poff = udp ? t + 7'd8 : t + 7'(hl);
    r.plen = udp ? 16'(ul - FRAME_COUNT_BITS'(8)) : 16'(tl - hl);
    for (int i = 0; i < 4; i++) begin
      r.seq[31-8*i -: 8] = udp ? 8'd0 : cb(t + 7'(4 + i), data_byte, byte_position);
      r.ack[31-8*i -: 8] = udp ? 8'd0 : cb(t + 7'(8 + i), data_byte, byte_position);
    end
  end
endmodule

### hw/rtl/eip_queue.sv
// Short record queue between the parser and the emitter.
// Depends on eip_pkg.
module eip_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  eip_pkg::frame_rec_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output eip_pkg::frame_rec_t rd_data
);
  import eip_pkg::*;
  localparam int AW = $clog2(QUEUE_DEPTH);

  frame_rec_t slots [QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] count;
  logic wr, rd;

  assign wr_ready = count != (AW+1)'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data = slots[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) slots[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

### hw/rtl/eip_emit.sv
// Back part: steps through a record and emits its tagged field run.
// Depends on eip_pkg.
module eip_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec_valid,
  output logic                rec_ready,
  input  eip_pkg::frame_rec_t rec,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          field_tag,
  output logic [63:0]         field_value,
  output logic                last_of_run
);
  import eip_pkg::*;

  logic [3:0] emit_index;
  logic drop, last, take;
  logic [63:0] val;

  assign drop = rec.cls == CLS_DROP;
  assign last = drop || emit_index == TAG_LAST;
  assign take = !out_valid || out_ready;
  assign rec_ready = rec_valid && take && last;

  always_comb begin
    case (emit_index)
      TAG_CLASS: val = 64'(rec.cls);
      TAG_ECN: val = 64'(rec.ecn);
      TAG_DST_MAC: val = 64'(rec.dst_mac);
      TAG_SRC_MAC: val = 64'(rec.src_mac);
      TAG_REM_HI: val = rec.rem_hi;
      TAG_REM_LO: val = rec.rem_lo;
      TAG_LOC_HI: val = rec.loc_hi;
      TAG_LOC_LO: val = rec.loc_lo;
      TAG_FAMILY: val = rec.is_v6 ? 64'd6 : 64'd4;
      TAG_REM_PORT: val = 64'(rec.rem_port);
      TAG_LOC_PORT: val = 64'(rec.loc_port);
      TAG_POFF: val = 64'(rec.poff);
      TAG_PLEN: val = 64'(rec.plen);
      TAG_SEQ: val = 64'(rec.seq);
      TAG_ACK: val = 64'(rec.ack);
      default: val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_index <= TAG_CLASS;
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= rec_valid;
      if (rec_valid) emit_index <= last ? TAG_CLASS : emit_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && rec_valid) begin
      field_tag <= emit_index;
      field_value <= val;
      last_of_run <= last;
    end
  end
endmodule

### tb/sv/tb_eip_if.sv
`timescale 1ns / 1ps
// Test-side copies are not needed: the block's own interfaces (eip_if.sv) are used.
// This file holds the field beat record type used by the testbench.
// Depends on nothing.
package tb_eip_types;
  typedef struct {
    logic [3:0]  field_tag;
    logic [63:0] field_value;
    logic        last_of_run;
  } field_beat_t;
endpackage

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for eth_ip_l4_header_parser: drives byte frames, predicts the tagged field runs.
// Depends on eip_pkg, eip_if (RTL) and tb_eip_types.
module testbench;
  import eip_pkg::*;
  import tb_eip_types::*;

  localparam int STALL_LIMIT = 4000;
  localparam int BYTE_BUDGET = 400;
  localparam logic [7:0] ET_V4_HI = 8'h08, ET_V6_HI = 8'h86, ET_V6_LO = 8'hDD;
  localparam logic [7:0] PROTO_UDP = 8'd17, PROTO_TCP = 8'd6;
  localparam logic [7:0] FLG_FIN = 8'h01, FLG_SYN = 8'h02, FLG_ACK = 8'h10;

  logic clk = 0;
  logic rst = 1;
  eip_byte_if in_ch (clk);
  eip_field_if out_ch (clk);

  eth_ip_l4_header_parser dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [7:0]  cap_mem [CAP_BYTES];
  logic [15:0] frame_count;
  field_beat_t pending_fields[$];
  bit typed_drop;
  int errors = 0;
  int frames_sent = 0, bytes_sent = 0, beats_seen = 0, drops_seen = 0;
  int idle_cycles = 0;
  int recv_gap;

  function automatic logic [63:0] wire_bytes(int off, int n);
    logic [63:0] v;
    v = 0;
    for (int i = 0; i < n; i++)
      v = (v << 8) | ((off + i < CAP_BYTES) ? cap_mem[off + i] : 8'h00);
    return v;
  endfunction

  // Returns the frame class; fills field values 1..12, and 13..14 for TCP.
  function automatic logic [2:0] classify_frame(int len, ref logic [63:0] vals[RUN_LEN]);
    int iplen, t, tl, plen, poff, tot, pl, ul, hl;
    logic [7:0] proto, flags;
    logic [2:0] cls;
    logic [63:0] etype;
    if (len < 14 || cap_mem[0][0]) return CLS_DROP;
    iplen = len - 14;
    etype = wire_bytes(12, 2);
    vals[2] = wire_bytes(0, 6);
    vals[3] = wire_bytes(6, 6);
    if (etype == 64'h0800) begin
      if (iplen < 20 || cap_mem[14] != 8'h45) return CLS_DROP;
      tot = int'(wire_bytes(16, 2));
      if (iplen < tot || tot < 20) return CLS_DROP;
      vals[1] = cap_mem[15] & 8'h03;
      proto = cap_mem[23];
      vals[4] = 0;
      vals[5] = wire_bytes(26, 4);
      vals[6] = 0;
      vals[7] = wire_bytes(30, 4);
      vals[8] = 4;
      t = 34;
      tl = tot - 20;
    end else if (etype == 64'h86DD) begin
      if (iplen < 40) return CLS_DROP;
      pl = int'(wire_bytes(18, 2));
      if (pl + 40 > iplen) return CLS_DROP;
      vals[1] = (cap_mem[15] >> 4) & 8'h03;
      proto = cap_mem[20];
      vals[4] = wire_bytes(22, 8);
      vals[5] = wire_bytes(30, 8);
      vals[6] = wire_bytes(38, 8);
      vals[7] = wire_bytes(46, 8);
      vals[8] = 6;
      t = 54;
      tl = pl;
    end else begin
      return CLS_DROP;
    end
    if (proto == PROTO_UDP) begin
      if (tl < 8) return CLS_DROP;
      ul = int'(wire_bytes(t + 4, 2));
      if (tl < ul || ul < 8) return CLS_DROP;
      cls = CLS_UDP;
      poff = t + 8;
      plen = ul - 8;
    end else if (proto == PROTO_TCP) begin
      if (tl < 20) return CLS_DROP;
      hl = int'(cap_mem[t + 12] >> 4) * 4;
      if (hl < 20 || tl < hl) return CLS_DROP;
      plen = tl - hl;
      flags = cap_mem[t + 13];
      if (flags == FLG_ACK && plen > 0) cls = CLS_TCP_DATA;
      else if (flags & FLG_SYN) cls = (flags & FLG_ACK) ? CLS_SYNACK : CLS_SYN;
      else if (flags & FLG_FIN) cls = CLS_FIN;
      else return CLS_DROP;
      poff = t + hl;
      vals[13] = wire_bytes(t + 4, 4);
      vals[14] = wire_bytes(t + 8, 4);
    end else begin
      return CLS_DROP;
    end
    vals[9] = wire_bytes(t, 2);
    vals[10] = wire_bytes(t + 2, 2);
    vals[11] = poff;
    vals[12] = plen;
    return cls;
  endfunction

  // Advance the predictor by one accepted byte; queue the run on the last byte.
  task automatic predict_byte(logic [7:0] b, logic eof);
    logic [63:0] vals[RUN_LEN];
    logic [2:0] cls;
    int len;
    field_beat_t fb;
    if (frame_count < CAP_BYTES) cap_mem[frame_count] = b;
    if (frame_count != 16'hFFFF) frame_count++;
    if (!eof) return;
    len = frame_count;
    frame_count = 0;
    for (int k = 0; k < RUN_LEN; k++) vals[k] = 0;
    cls = classify_frame(len, vals);
    // rows with a typed-in drop expect the single drop beat outright
    if (typed_drop || cls == CLS_DROP) begin
      fb = '{TAG_CLASS, 64'd0, 1'b1};
      pending_fields.push_back(fb);
      return;
    end
    vals[0] = cls;
    for (int k = 0; k < RUN_LEN; k++) begin
      fb = '{4'(k), vals[k], 1'(k == RUN_LEN - 1)};
      pending_fields.push_back(fb);
    end
  endtask

  // Sink side: random stalls, compare each beat with the oldest expectation.
  always @(posedge clk) begin
    field_beat_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        beats_seen++;
        if (pending_fields.size() == 0) begin
          $error("unexpected beat tag=%0d value=%h", out_ch.field_tag, out_ch.field_value);
          errors++;
        end else begin
          want = pending_fields.pop_front();
          if (want.field_tag == TAG_CLASS && want.last_of_run) drops_seen++;
          if (out_ch.field_tag !== want.field_tag) begin
            $error("field_tag: expected %0d, got %0d", want.field_tag, out_ch.field_tag);
            errors++;
          end
          if (out_ch.field_value !== want.field_value) begin
            $error("field_value (tag %0d): expected %h, got %h", want.field_tag,
                   want.field_value, out_ch.field_value);
            errors++;
          end
          if (out_ch.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, out_ch.last_of_run);
            errors++;
          end
        end
        // draw a stall for the next beat
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no beat on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("eth_ip_l4_header_parser verification failed");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  logic [7:0] frame_buf[$];
  bit burst_mode;

  task automatic send_byte(logic [7:0] b, logic eof);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_frame <= eof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(b, eof);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  function automatic void put16(int off, int v);
    frame_buf[off] = v[15:8];
    frame_buf[off + 1] = v[7:0];
  endfunction

  // Build a well-formed frame; fam 4 or 6, proto UDP/TCP, then callers may corrupt it.
  function automatic void build_frame(int fam, logic [7:0] proto, logic [7:0] flags,
                                      int hl_words, int plen, int pad);
    int t, tl, n;
    t = (fam == 4) ? 34 : 54;
    tl = (proto == PROTO_TCP) ? hl_words * 4 + plen : 8 + plen;
    n = t + tl + pad;
    frame_buf.delete();
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
    frame_buf[0][0] = 1'b0;
    if (fam == 4) begin
      frame_buf[12] = ET_V4_HI;
      frame_buf[13] = 8'h00;
      frame_buf[14] = 8'h45;
      put16(16, tl + 20);
      frame_buf[23] = proto;
    end else begin
      frame_buf[12] = ET_V6_HI;
      frame_buf[13] = ET_V6_LO;
      put16(18, tl);
      frame_buf[20] = proto;
    end
    if (proto == PROTO_TCP) begin
      frame_buf[t + 12] = {4'(hl_words), frame_buf[t + 12][3:0]};
      frame_buf[t + 13] = flags;
    end else begin
      put16(t + 4, 8 + plen);
    end
  endfunction

  // Drop valid, then hold until every expected beat has come.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
  endtask

  // Directed table: one row per frame shape; exp_drop marks a typed-in drop.
  typedef struct {
    int fam; logic [7:0] proto; logic [7:0] flags; int hl; int plen; int pad; int mangle;
    bit exp_drop;
  } frame_row_t;
  localparam int MG_NONE = 0, MG_SHORT = 1, MG_MCAST = 2, MG_ETYPE = 3, MG_IHL = 4,
                 MG_PROTO = 5, MG_UDPLEN = 6, MG_TCPHL = 7, MG_TOTLEN = 8;
  frame_row_t dir_rows[] = '{
    '{4, PROTO_UDP, 8'h00, 5, 0, 0, MG_NONE, 0},
    '{4, PROTO_TCP, FLG_ACK, 5, 1, 0, MG_NONE, 0},
    '{6, PROTO_TCP, FLG_SYN | FLG_ACK, 5, 0, 2, MG_NONE, 0},
    '{4, PROTO_UDP, 8'h00, 5, 0, 0, MG_SHORT, 1},
    '{4, PROTO_UDP, 8'h00, 5, 0, 0, MG_MCAST, 1},
    '{4, PROTO_UDP, 8'h00, 5, 0, 0, MG_UDPLEN, 1},
    '{4, PROTO_UDP, 8'h00, 5, 0, 0, MG_TOTLEN, 1}
  };

  function automatic void mangle_frame(int mg, int fam);
    int t;
    t = (fam == 4) ? 34 : 54;
    case (mg)
      MG_SHORT:  while (frame_buf.size() > $urandom_range(1, 13)) void'(frame_buf.pop_back());
      MG_MCAST:  frame_buf[0][0] = 1'b1;
      MG_ETYPE:  frame_buf[13] = frame_buf[13] ^ 8'h01;
      MG_IHL:    if (fam == 4) frame_buf[14] = 8'h46; else frame_buf[13] = 8'h00;
      MG_PROTO:  frame_buf[fam == 4 ? 23 : 20] = 8'd1;
      MG_UDPLEN: put16(t + 4, $urandom_range(0, 7));
      MG_TCPHL:  frame_buf[t + 12][7:4] = 4'($urandom_range(0, 4));
      MG_TOTLEN: if (fam == 4) put16(16, $urandom_range(0, 19) + (frame_buf.size() - 14) *
                                          $urandom_range(0, 1) + 1);
      default: ;
    endcase
  endfunction

  initial begin
    int pick, mg;
    frame_row_t row;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.end_of_frame = 1'b0;
    out_ch.ready = 1'b0;
    frame_count = 0;
    foreach (cap_mem[i]) cap_mem[i] = 0;
    burst_mode = 0;
    typed_drop = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone end-of-frame byte straight after reset: always a drop
    typed_drop = 1;
    frame_buf = '{8'hFF};
    send_frame();
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      typed_drop = row.exp_drop;
      build_frame(row.fam, row.proto, row.flags, row.hl, row.plen, row.pad);
      mangle_frame(row.mangle, row.fam);
      send_frame();
    end
    typed_drop = 0;
    // drain fully before the random part
    wait_drained();

    while (bytes_sent < BYTE_BUDGET) begin
      pick = $urandom_range(0, 99);
      burst_mode = ($urandom_range(0, 7) == 0);
      if (pick < 70) begin
        row.fam = $urandom_range(0, 1) ? 4 : 6;
        row.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        case ($urandom_range(0, 5))
          0: row.flags = FLG_ACK;
          1: row.flags = FLG_SYN;
          2: row.flags = FLG_SYN | FLG_ACK;
          3: row.flags = FLG_FIN | FLG_ACK;
          default: row.flags = 8'($urandom);
        endcase
        row.hl = $urandom_range(5, 15);
        row.plen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 6);
        row.pad = $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0;
        build_frame(row.fam, row.proto, row.flags, row.hl, row.plen, row.pad);
        mg = (pick < 45) ? MG_NONE : $urandom_range(MG_SHORT, MG_TOTLEN);
        mangle_frame(mg, row.fam);
      end else begin
        frame_buf.delete();
        repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
      end
      send_frame();
      // hold until every run is out, once in a while
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d frames (%0d bytes), %0d field beats, %0d dropped frames.",
             frames_sent, bytes_sent, beats_seen, drops_seen);
    if (errors == 0) begin
      $display("eth_ip_l4_header_parser verification clean");
    end else begin
      $display("eth_ip_l4_header_parser verification failed");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/eip_pkg.sv
hw/rtl/eip_if.sv
hw/rtl/eip_parse.sv
hw/rtl/eip_queue.sv
hw/rtl/eip_emit.sv
hw/rtl/eth_ip_l4_header_parser.sv
tb/sv/tb_eip_if.sv
tb/sv/testbench.sv
